@@ src/weds_pkg.sv @@
package weds_pkg;

  // Width of one stored error term (two's complement).
  localparam int unsigned ERR_BITS = 13;

  // Width of the result field and of the register index on the config port.
  localparam int unsigned COMP_BITS    = 3;
  localparam int unsigned CFG_IDX_BITS = 4;

  // Number of weight registers in the register map.
  localparam int unsigned REG_COUNT = 8;

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_BITS  = 8;
  localparam int unsigned OUT_TDATA_BITS = 8;

  // Saturation limits of an error term.
  localparam int ERR_MAX = (1 << (ERR_BITS - 1)) - 1;
  localparam int ERR_MIN = -(1 << (ERR_BITS - 1));

  typedef logic signed [ERR_BITS-1:0] err_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIX
  } fsm_e;

endpackage

@@ src/weighted_error_diffusion_selector.sv @@
// Weighted error-diffusion component selector (smooth weighted round robin).
//
// Each transfer on the slave stream is one layer step; tdata bit 0 is the
// restart flag, which clears every error term before that step. For each
// step the block adds every component's weight to its error term, picks the
// component with the largest error (lowest index on a tie), subtracts the
// weight total from the picked error and sends the picked index as one
// transfer on the master stream. If all weights are zero the answer is
// component 0 and the errors stay as they are.
// The error terms live in a small synchronous RAM that is scanned once per
// step, one entry per cycle. The slave side is ready only while idle, so a
// new step is not accepted before the current one is done; the single RAM
// read port, visiting each entry once, sets the step spacing. The user must
// write weights through the plain config port only while the block is idle;
// the block itself does not enforce it. Reset returns weights 0 and 1 to one,
// all others to zero, and marks every error as zero through per-entry valid
// bits. When the receiver stalls, the result is held in the output register;
// the block still accepts and computes the next step, and only then waits for
// the register to drain.
module weighted_error_diffusion_selector #(
  parameter int unsigned NUM_COMPONENTS = 8,
  parameter int unsigned WEIGHT_BITS    = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration writes.
  input  logic                                cfg_we_i,
  input  logic [weds_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [WEIGHT_BITS-1:0]              cfg_data_i,
  // Slave stream: one layer step per transfer.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [weds_pkg::IN_TDATA_BITS-1:0]  s_axis_tdata,   // [0] restart
  // Master stream: one chosen component per step.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [weds_pkg::OUT_TDATA_BITS-1:0] m_axis_tdata    // [2:0] component
);

  import weds_pkg::*;

  localparam int unsigned IDX_W = $clog2(NUM_COMPONENTS);
  // Running total of the weights.
  localparam int unsigned TOT_W = WEIGHT_BITS + IDX_W;
  // Error plus weight, and error minus total, with room for the sign.
  localparam int unsigned SUM_W = ((WEIGHT_BITS + 1 > ERR_BITS) ? WEIGHT_BITS + 1 : ERR_BITS) + 1;
  localparam int unsigned DIF_W = ((TOT_W + 1 > ERR_BITS) ? TOT_W + 1 : ERR_BITS) + 1;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(ERR_MAX);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(ERR_MIN);
  localparam logic signed [DIF_W-1:0] DIF_MAX = DIF_W'(ERR_MAX);
  localparam logic signed [DIF_W-1:0] DIF_MIN = DIF_W'(ERR_MIN);
  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(NUM_COMPONENTS - 1);

  // Weight registers; writes to components beyond NUM_COMPONENTS are dropped.
  logic [WEIGHT_BITS-1:0] weight_q [NUM_COMPONENTS];

  fsm_e                    state_q, state_d;
  logic [IDX_W-1:0]        cnt_q, cnt_d;
  logic [IDX_W-1:0]        pick_q, pick_d;
  err_t                    best_q, best_d;
  logic [TOT_W-1:0]        total_q, total_d;
  logic [NUM_COMPONENTS-1:0] valid_q, valid_d;
  logic                    out_vld_q, out_vld_d;
  logic [COMP_BITS-1:0]    out_comp_q, out_comp_d;

  logic                    ram_we;
  logic [IDX_W-1:0]        ram_waddr;
  err_t                    ram_wdata;
  logic                    ram_re;
  logic [IDX_W-1:0]        ram_raddr;
  logic [ERR_BITS-1:0]     ram_rdata;

  err_t                    old_err;
  logic [WEIGHT_BITS-1:0]  cur_weight;
  logic signed [SUM_W-1:0] sum_wide;
  err_t                    new_err;
  logic signed [DIF_W-1:0] dif_wide;
  err_t                    fix_err;

  weds_ram #(
    .WIDTH (ERR_BITS),
    .DEPTH (NUM_COMPONENTS)
  ) u_err_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_COMPONENTS; k++) begin
        weight_q[k] <= (k < 2) ? WEIGHT_BITS'(1) : '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_BITS'(NUM_COMPONENTS))) begin
      weight_q[cfg_idx_i[IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // An entry that has not been written since reset or restart reads as zero.
  assign old_err    = valid_q[cnt_q] ? err_t'(ram_rdata) : '0;
  assign cur_weight = weight_q[cnt_q];

  // Error plus this component's weight, saturated to the stored range.
  assign sum_wide = signed'({{(SUM_W - ERR_BITS){old_err[ERR_BITS-1]}}, old_err})
                  + signed'({{(SUM_W - WEIGHT_BITS){1'b0}}, cur_weight});

  always_comb begin
    if (sum_wide > SUM_MAX) begin
      new_err = err_t'(ERR_MAX);
    end else if (sum_wide < SUM_MIN) begin
      new_err = err_t'(ERR_MIN);
    end else begin
      new_err = sum_wide[ERR_BITS-1:0];
    end
  end

  // Picked error minus the weight total, saturated likewise.
  assign dif_wide = signed'({{(DIF_W - ERR_BITS){best_q[ERR_BITS-1]}}, best_q})
                  - signed'({{(DIF_W - TOT_W){1'b0}}, total_q});

  always_comb begin
    if (dif_wide > DIF_MAX) begin
      fix_err = err_t'(ERR_MAX);
    end else if (dif_wide < DIF_MIN) begin
      fix_err = err_t'(ERR_MIN);
    end else begin
      fix_err = dif_wide[ERR_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pick_q     <= pick_d;
    best_q     <= best_d;
    total_q    <= total_d;
    out_comp_q <= out_comp_d;
  end

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    pick_d        = pick_q;
    best_d        = best_q;
    total_d       = total_q;
    valid_d       = valid_q;
    out_vld_d     = out_vld_q;
    out_comp_d    = out_comp_q;
    ram_we        = 1'b0;
    ram_waddr     = cnt_q;
    ram_wdata     = new_err;
    ram_re        = 1'b0;
    ram_raddr     = cnt_q + IDX_W'(1);
    s_axis_tready = 1'b0;

    if (out_vld_q && m_axis_tready) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          if (s_axis_tdata[0]) begin
            valid_d = '0;
          end
          ram_re    = 1'b1;
          ram_raddr = '0;
          cnt_d     = '0;
          state_d   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Read data for entry cnt_q is here; write its update back and
        // fetch the next entry in the same cycle.
        ram_we         = 1'b1;
        valid_d[cnt_q] = 1'b1;
        total_d = ((cnt_q == '0) ? '0 : total_q) + {{IDX_W{1'b0}}, cur_weight};
        if ((cnt_q == '0) || (new_err > best_q)) begin
          best_d = new_err;
          pick_d = cnt_q;
        end
        if (cnt_q == LAST_IDX) begin
          state_d = ST_FIX;
        end else begin
          cnt_d  = cnt_q + IDX_W'(1);
          ram_re = 1'b1;
        end
      end
      ST_FIX: begin
        // Wait here until the output register is free, then finish the step.
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d = 1'b1;
          if (total_q != '0) begin
            ram_we     = 1'b1;
            ram_waddr  = pick_q;
            ram_wdata  = fix_err;
            out_comp_d = COMP_BITS'(pick_q);
          end else begin
            out_comp_d = '0;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{(OUT_TDATA_BITS - COMP_BITS){1'b0}}, out_comp_q};

endmodule

@@ src/weds_ram.sv @@
module weds_ram #(
  parameter int unsigned WIDTH = 13,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
